>>> rtl/gphat_pkg.sv
// Package for the gamepad poll and hat encoder.
// Field widths, register map, poll phases and the hat encoding and button packing functions.
// No dependencies.
package gphat_pkg;

    localparam int BITS_PER_POLL = 16;
    localparam int CAPTURE_BITS  = 16;
    localparam int POS_W         = 5;
    localparam int TICK_W        = 8;
    localparam int HAT_W         = 4;
    localparam int BTN_W         = 8;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic [TICK_W-1:0] LATCH_TICKS_RST = 8'd12;
    localparam logic [TICK_W-1:0] PHASE_TICKS_RST = 8'd6;

    typedef enum logic [0:0] {
        REG_LATCH_TICKS = 1'b0,
        REG_PHASE_TICKS = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_LATCH = 3'd1,
        PH_PRE   = 3'd2,
        PH_HIGH  = 3'd3,
        PH_LOW   = 3'd4
    } poll_phase_t;

    localparam logic [HAT_W-1:0] HAT_NEUTRAL    = 4'd0;
    localparam logic [HAT_W-1:0] HAT_NORTH      = 4'd1;
    localparam logic [HAT_W-1:0] HAT_NORTH_EAST = 4'd2;
    localparam logic [HAT_W-1:0] HAT_EAST       = 4'd3;
    localparam logic [HAT_W-1:0] HAT_SOUTH_EAST = 4'd4;
    localparam logic [HAT_W-1:0] HAT_SOUTH      = 4'd5;
    localparam logic [HAT_W-1:0] HAT_SOUTH_WEST = 4'd6;
    localparam logic [HAT_W-1:0] HAT_WEST       = 4'd7;
    localparam logic [HAT_W-1:0] HAT_NORTH_WEST = 4'd8;

    // up beats down; right beats left with up or down, left beats right otherwise
    function automatic logic [HAT_W-1:0] encode_hat(input logic [CAPTURE_BITS-1:0] v);
        logic up;
        logic down;
        logic left;
        logic right;
        logic [HAT_W-1:0] h;
        up    = v[4];
        down  = v[5];
        left  = v[6];
        right = v[7];
        if (up)
            h = right ? HAT_NORTH_EAST : (left ? HAT_NORTH_WEST : HAT_NORTH);
        else if (down)
            h = right ? HAT_SOUTH_EAST : (left ? HAT_SOUTH_WEST : HAT_SOUTH);
        else if (left)
            h = HAT_WEST;
        else if (right)
            h = HAT_EAST;
        else
            h = HAT_NEUTRAL;
        return h;
    endfunction

    function automatic logic [BTN_W-1:0] pack_buttons(input logic [CAPTURE_BITS-1:0] v);
        return {v[11:8], v[3:0]};
    endfunction

endpackage

>>> rtl/gphat_if.sv
// Channel interfaces for the gamepad poll and hat encoder.
// Tick input channel and report output channel; no dependencies.
interface gphat_in_if;
    logic valid;
    logic ready;
    logic data_pin;
    logic host_ready;

    modport source (output valid, output data_pin, output host_ready, input ready);
    modport sink   (input valid, input data_pin, input host_ready, output ready);
endinterface

interface gphat_out_if;
    logic       valid;
    logic       ready;
    logic       latch_line;
    logic       clock_line;
    logic       report_valid;
    logic [3:0] hat;
    logic [7:0] buttons;

    modport source (output valid, output latch_line, output clock_line, output report_valid,
                    output hat, output buttons, input ready);
    modport sink   (input valid, input latch_line, input clock_line, input report_valid,
                    input hat, input buttons, output ready);
endinterface

>>> rtl/gamepad_serial_poll_hat_encode.sv
// Top level of the gamepad poll and hat encoder.
// Depends on gphat_pkg and the channel interfaces in gphat_if.sv.
//
// Usage:
//   in_ch carries one timing tick per transaction (data_pin, host_ready).
//   out_ch returns exactly one transaction per tick: latch and clock drive
//   levels, and on the last tick of a poll the report (hat, buttons).
//   A poll starts from idle when host_ready is 1: latch is high for
//   latch_ticks ticks, then 16 bits are read, three phases of phase_ticks
//   ticks each (sample with clock low, clock high, clock low).
//   Registers (APB, byte address 0: latch_ticks, 4: phase_ticks) must be
//   written while no poll is running (not enforced here); a value of 0 acts as 1.
// Output: the result of a tick is presented in the cycle after acceptance.
// Throughput: one tick per cycle unless stalled; the poll state and the
//   result register are updated together in the accepting cycle.
// Reset: poll state goes idle, registers return to 12 and 6, the output
//   register is emptied.
// Stall: in_ch.ready drops only while a result is held and out_ch.ready is
//   low; the held result stays stable until taken.
module gamepad_serial_poll_hat_encode
    import gphat_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    gphat_in_if.sink          in_ch,
    gphat_out_if.source       out_ch
);

    logic [TICK_W-1:0]       latch_ticks_reg;
    logic [TICK_W-1:0]       phase_ticks_reg;
    poll_phase_t             phase_reg, phase_next;
    logic [TICK_W-1:0]       timer_reg, timer_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [CAPTURE_BITS-1:0] cap_reg, cap_next;

    logic              out_valid_reg;
    logic              latch_reg, latch_next;
    logic              clock_reg, clock_next;
    logic              rpt_reg, rpt_next;
    logic [HAT_W-1:0]  hat_reg, hat_next;
    logic [BTN_W-1:0]  btn_reg, btn_next;

    logic     accept;
    logic     cfg_wr;
    reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_comb
    begin
        unique case (cfg_idx)
            REG_LATCH_TICKS: prdata = {{(APB_DW-TICK_W){1'b0}}, latch_ticks_reg};
            REG_PHASE_TICKS: prdata = {{(APB_DW-TICK_W){1'b0}}, phase_ticks_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_ticks_reg <= LATCH_TICKS_RST;
            phase_ticks_reg <= PHASE_TICKS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_LATCH_TICKS: latch_ticks_reg <= pwdata[TICK_W-1:0];
                REG_PHASE_TICKS: phase_ticks_reg <= pwdata[TICK_W-1:0];
                default:         ;
            endcase
        end
    end

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        poll_phase_t       ph;
        logic [TICK_W-1:0] tmr;
        logic [TICK_W-1:0] tinc;
        logic [TICK_W-1:0] lim;
        logic              done;
        logic [POS_W:0]    pos_inc;

        ph   = phase_reg;
        tmr  = timer_reg;
        pos_next = pos_reg;
        cap_next = cap_reg;
        latch_next = 1'b0;
        clock_next = 1'b0;
        rpt_next   = 1'b0;
        hat_next   = HAT_NEUTRAL;
        btn_next   = '0;

        if (ph != PH_LATCH && ph != PH_PRE && ph != PH_HIGH && ph != PH_LOW)
            ph = PH_IDLE;

        if (ph == PH_IDLE && in_ch.host_ready)
        begin
            ph       = PH_LATCH;
            tmr      = '0;
            pos_next = '0;
            cap_next = '0;
        end

        tinc    = tmr + 1'b1;
        lim     = (ph == PH_LATCH) ? latch_ticks_reg : phase_ticks_reg;
        done    = (tinc >= lim) || (tinc == '0);
        pos_inc = {1'b0, pos_next} + 1'b1;

        phase_next = ph;
        timer_next = tmr;

        unique case (ph)
            PH_LATCH:
            begin
                latch_next = 1'b1;
                timer_next = done ? '0 : tinc;
                if (done)
                    phase_next = PH_PRE;
            end
            PH_PRE:
            begin
                if (tmr == '0 && !pos_next[POS_W-1] && !in_ch.data_pin)
                    cap_next[pos_next[3:0]] = 1'b1;
                timer_next = done ? '0 : tinc;
                if (done)
                    phase_next = PH_HIGH;
            end
            PH_HIGH:
            begin
                clock_next = 1'b1;
                timer_next = done ? '0 : tinc;
                if (done)
                    phase_next = PH_LOW;
            end
            PH_LOW:
            begin
                timer_next = done ? '0 : tinc;
                if (done)
                begin
                    if (pos_inc >= (POS_W+1)'(BITS_PER_POLL))
                    begin
                        rpt_next   = 1'b1;
                        hat_next   = encode_hat(cap_reg);
                        btn_next   = pack_buttons(cap_reg);
                        pos_next   = '0;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_inc[POS_W-1:0];
                        phase_next = PH_PRE;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= '0;
            pos_reg       <= '0;
            cap_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                timer_reg <= timer_next;
                pos_reg   <= pos_next;
                cap_reg   <= cap_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            latch_reg <= latch_next;
            clock_reg <= clock_next;
            rpt_reg   <= rpt_next;
            hat_reg   <= hat_next;
            btn_reg   <= btn_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.latch_line   = latch_reg;
    assign out_ch.clock_line   = clock_reg;
    assign out_ch.report_valid = rpt_reg;
    assign out_ch.hat          = hat_reg;
    assign out_ch.buttons      = btn_reg;

endmodule

>>> rtl/gphat_checker.sv
// Port-level checker for the gamepad poll and hat encoder, with its bind.
// Depends on gphat_pkg and gamepad_serial_poll_hat_encode.
module gphat_checker
    import gphat_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic             latch_line,
    input logic             clock_line,
    input logic             report_valid,
    input logic [HAT_W-1:0] hat,
    input logic [BTN_W-1:0] buttons
);

    // held result must not change while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({latch_line, clock_line,
            report_valid, hat, buttons}))
        else $error("result changed while stalled");

    // no transaction taken on input can be refused while output is free
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    // every accepted tick yields a held result on the next cycle
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted tick produced no result");

    a_lines: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(latch_line && clock_line)
            && !(report_valid && (latch_line || clock_line)))
        else $error("illegal latch/clock/report combination");

    a_idle_report: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !report_valid |-> hat == HAT_NEUTRAL && buttons == '0)
        else $error("report fields nonzero without report");

endmodule

bind gamepad_serial_poll_hat_encode gphat_checker u_gphat_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .latch_line   (out_ch.latch_line),
    .clock_line   (out_ch.clock_line),
    .report_valid (out_ch.report_valid),
    .hat          (out_ch.hat),
    .buttons      (out_ch.buttons)
);

>>> sim/gamepad_serial_poll_hat_encode_checker.sv
`timescale 1ns / 100ps
// Scoreboard for gamepad_serial_poll_hat_encode: tracks APB register writes and
// accepted ticks, predicts each tick's drive levels and report, compares out_ch.
// Depends on gphat_pkg and the channel interfaces in gphat_if.sv.
module gamepad_serial_poll_hat_encode_checker
    import gphat_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    gphat_in_if               in_mon,
    gphat_out_if              out_mon,
    output int                errors,
    output int                outstanding
);

    typedef struct packed {
        logic             latch_line;
        logic             clock_line;
        logic             report_valid;
        logic [HAT_W-1:0] hat;
        logic [BTN_W-1:0] buttons;
    } drive_t;

    drive_t                  drive_q[$];
    logic [TICK_W-1:0]       latch_len;
    logic [TICK_W-1:0]       phase_len;
    logic [TICK_W-1:0]       timer;
    poll_phase_t             phase;
    logic [POS_W-1:0]        bit_pos;
    logic [CAPTURE_BITS-1:0] capture;

    // order is {up, down, left, right}; left beats right only with no vertical
    function automatic logic [HAT_W-1:0] hat_of(input logic [CAPTURE_BITS-1:0] v);
        logic [HAT_W-1:0] h;
        casez ({v[4], v[5], v[6], v[7]})
            4'b1??1: h = HAT_NORTH_EAST;
            4'b1?10: h = HAT_NORTH_WEST;
            4'b1?00: h = HAT_NORTH;
            4'b01?1: h = HAT_SOUTH_EAST;
            4'b0110: h = HAT_SOUTH_WEST;
            4'b0100: h = HAT_SOUTH;
            4'b001?: h = HAT_WEST;
            4'b0001: h = HAT_EAST;
            default: h = HAT_NEUTRAL;
        endcase
        return h;
    endfunction

    // a limit of 0 ends the phase after one tick, same as 1
    function bit phase_over(input logic [TICK_W-1:0] lim);
        timer = timer + 1'b1;
        if (timer >= lim || timer == '0)
        begin
            timer = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task predict_tick(input logic data_pin, input logic host_ready, output drive_t d);
        d = '0;
        if (phase == PH_IDLE && host_ready)
        begin
            phase   = PH_LATCH;
            timer   = '0;
            bit_pos = '0;
            capture = '0;
        end
        case (phase)
            PH_LATCH:
            begin
                d.latch_line = 1'b1;
                if (phase_over(latch_len))
                    phase = PH_PRE;
            end
            PH_PRE:
            begin
                if (timer == '0 && bit_pos < CAPTURE_BITS && !data_pin)
                    capture[bit_pos[3:0]] = 1'b1;
                if (phase_over(phase_len))
                    phase = PH_HIGH;
            end
            PH_HIGH:
            begin
                d.clock_line = 1'b1;
                if (phase_over(phase_len))
                    phase = PH_LOW;
            end
            PH_LOW:
            begin
                if (phase_over(phase_len))
                begin
                    if (int'(bit_pos) + 1 >= BITS_PER_POLL)
                    begin
                        d.report_valid = 1'b1;
                        d.hat          = hat_of(capture);
                        d.buttons      = {capture[11:8], capture[3:0]};
                        bit_pos        = '0;
                        phase          = PH_IDLE;
                    end
                    else
                    begin
                        bit_pos = bit_pos + 1'b1;
                        phase   = PH_PRE;
                    end
                end
            end
            default:
                phase = PH_IDLE;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : score
        drive_t want;
        drive_t got;
        if (!rst_n)
        begin
            latch_len = LATCH_TICKS_RST;
            phase_len = PHASE_TICKS_RST;
            phase     = PH_IDLE;
            timer     = '0;
            bit_pos   = '0;
            capture   = '0;
            errors    = 0;
            drive_q.delete();
        end
        else
        begin
            if (in_mon.valid && in_mon.ready)
            begin
                predict_tick(in_mon.data_pin, in_mon.host_ready, want);
                drive_q.push_back(want);
            end
            if (out_mon.valid && out_mon.ready)
            begin
                got = {out_mon.latch_line, out_mon.clock_line, out_mon.report_valid,
                       out_mon.hat, out_mon.buttons};
                if (drive_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"%0t: transaction with nothing expected: ",
                                  "latch=%b clock=%b report=%b hat=%0d buttons=%h"},
                                 $time, got.latch_line, got.clock_line, got.report_valid,
                                 got.hat, got.buttons);
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (got.latch_line !== want.latch_line ||
                        got.clock_line !== want.clock_line ||
                        got.report_valid !== want.report_valid || got.hat !== want.hat ||
                        got.buttons !== want.buttons)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display({"%0t: mismatch, expected latch=%b clock=%b ",
                                      "report=%b hat=%0d buttons=%h"},
                                     $time, want.latch_line, want.clock_line,
                                     want.report_valid, want.hat, want.buttons);
                            $display({"%0t:           actual   latch=%b clock=%b ",
                                      "report=%b hat=%0d buttons=%h"},
                                     $time, got.latch_line, got.clock_line,
                                     got.report_valid, got.hat, got.buttons);
                        end
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[2]))
                    REG_LATCH_TICKS: latch_len = pwdata[TICK_W-1:0];
                    REG_PHASE_TICKS: phase_len = pwdata[TICK_W-1:0];
                    default: ;
                endcase
            end
        end
        outstanding = drive_q.size();
    end

endmodule

>>> sim/gamepad_serial_poll_hat_encode_tb.sv
`timescale 1ns / 100ps
// Top of the gamepad_serial_poll_hat_encode testbench: clock, reset, APB writes,
// tick stimulus made of aligned polls with fixed and random content, and the verdict.
// Depends on gphat_pkg, the channel interfaces and the checker module.
module gamepad_serial_poll_hat_encode_tb;
    import gphat_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_TICKS = 450;
    localparam int NUM_SETTINGS = 8;
    localparam int NUM_PATTERNS = 14;

    localparam int SET_LATCH [NUM_SETTINGS] = '{2, 1, 0, 1, 3, 6, 1, 2};
    localparam int SET_PHASE [NUM_SETTINGS] = '{1, 2, 1, 0, 2, 3, 1, 2};

    // {R,L,X,A} {Right,Left,Down,Up} {Start,Select,Y,B} in capture order
    localparam logic [15:0] PATTERNS [NUM_PATTERNS] = '{
        16'h0000, 16'hFFFF, 16'h0010, 16'h0090, 16'h0050, 16'h0020, 16'h00A0,
        16'h0060, 16'h0040, 16'h0080, 16'h00F0, 16'h0030, 16'h00C0, 16'h0A05
    };

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int errors;
    int outstanding;
    int tx_idle    = 0;
    int rx_idle    = 0;
    int quiet      = 0;
    int poll_ticks = 0;
    int cur_latch  = int'(LATCH_TICKS_RST);
    int cur_phase  = int'(PHASE_TICKS_RST);
    int poll_num;
    int sel;

    gphat_in_if  in_ch();
    gphat_out_if out_ch();

    gamepad_serial_poll_hat_encode dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    gamepad_serial_poll_hat_encode_checker score (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always #10 clk = ~clk;

    always @(negedge clk)
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle);

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet <= 0;
        else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // entered and left at a falling edge; valid stays high into the next tick
    task automatic send_tick(input logic data_pin, input logic host_ready);
        while ($urandom_range(0, 99) < tx_idle)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_pin   <= data_pin;
        in_ch.host_ready <= host_ready;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic idle_ticks(input int n);
        repeat (n)
            send_tick(1'($urandom_range(0, 1)), 1'b0);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    task automatic apb_write(input reg_idx_t idx, input int value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_timing(input int latch_val, input int phase_val);
        wait_drained();
        repeat (2)
            @(negedge clk);
        apb_write(REG_LATCH_TICKS, latch_val);
        apb_write(REG_PHASE_TICKS, phase_val);
        cur_latch = latch_val;
        cur_phase = phase_val;
    endtask

    // one full poll; the pin carries the pressed pattern on each sample tick
    task automatic run_poll(input logic [15:0] pressed);
        int lt;
        int pt;
        int total;
        int off;
        int hold_at;
        logic pin;
        lt      = (cur_latch == 0) ? 1 : cur_latch;
        pt      = (cur_phase == 0) ? 1 : cur_phase;
        total   = lt + BITS_PER_POLL * 3 * pt;
        hold_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total - 1) : -1;
        for (int k = 0; k < total; k++)
        begin
            if (k == hold_at)
                wait_drained();
            off = k - lt;
            if (off >= 0 && off % (3 * pt) == 0)
                pin = ~pressed[off / (3 * pt)];
            else
                pin = 1'($urandom_range(0, 1));
            send_tick(pin, (k == 0) ? 1'b1 : 1'($urandom_range(0, 1)));
            poll_ticks++;
        end
    endtask

    initial
    begin
        in_ch.valid      = 1'b0;
        in_ch.data_pin   = 1'b1;
        in_ch.host_ready = 1'b0;
        repeat (2)
            @(negedge clk);
        rst_n = 1'b1;

        tx_idle = 18;
        rx_idle = 65;
        idle_ticks(4);
        run_poll(16'hFFFF);
        set_timing(1, 1);
        for (int i = 0; i < NUM_PATTERNS; i++)
            run_poll(PATTERNS[i]);
        idle_ticks(2);
        set_timing(0, 0);
        run_poll(16'h0F0F);
        run_poll(16'h5A5A);

        poll_ticks = 0;
        poll_num   = 0;
        while (poll_ticks < RANDOM_TICKS)
        begin
            if (poll_ticks < RANDOM_TICKS / 3)
            begin
                tx_idle = 18;
                rx_idle = 65;
            end
            else if (poll_ticks < 2 * RANDOM_TICKS / 3)
            begin
                tx_idle = 65;
                rx_idle = 18;
            end
            else
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
            if (poll_num % 3 == 0)
            begin
                sel = poll_num / 3;
                if (sel < NUM_SETTINGS)
                    set_timing(SET_LATCH[sel], SET_PHASE[sel]);
                else
                    set_timing($urandom_range(0, 5), $urandom_range(0, 3));
            end
            if ($urandom_range(0, 1))
                idle_ticks($urandom_range(1, 4));
            run_poll(16'($urandom_range(0, 16'hFFFF)));
            poll_num++;
        end

        tx_idle = 0;
        rx_idle = 0;
        set_timing(255, 1);
        run_poll(16'($urandom_range(0, 16'hFFFF)));

        wait_drained();
        repeat (10)
            @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
